FILE: sv/rrm_pkg.sv
// ----------------------------------------------------------------------------
// rrm_pkg: shared types and constants
// Register map, fixed field widths and pipeline control bundle for the
// requantize / ReLU / max-pool block.
// ----------------------------------------------------------------------------
package rrm_pkg;

	localparam int NUM_LANES   = 4;
	localparam int LVALID_BITS = 3;
	localparam int SCALE_BITS  = 48;
	localparam int MUL_SPLIT   = 32;   // low slice of the multiplier, per partial product
	localparam int APB_DW      = 64;
	localparam int PADDR_BITS  = 5;

	typedef enum logic [1:0] {
		REG_SCALE    = 2'd0,
		REG_RELU     = 2'd1,
		REG_CLAMP_LO = 2'd2,
		REG_CLAMP_HI = 2'd3
	} reg_idx_t;

	// load enables of the lane pipeline stages
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} pipe_ctl_t;

endpackage

FILE: sv/rrm_acc_if.sv
// ----------------------------------------------------------------------------
// rrm_acc_if: accumulator channel
// Valid/ready channel carrying four accumulators and the valid lane count.
// ----------------------------------------------------------------------------
interface rrm_acc_if #(
	parameter int ACC_BITS = 32
);
	logic                       valid;
	logic                       ready;
	logic signed [ACC_BITS-1:0] acc_lane0;
	logic signed [ACC_BITS-1:0] acc_lane1;
	logic signed [ACC_BITS-1:0] acc_lane2;
	logic signed [ACC_BITS-1:0] acc_lane3;
	logic [2:0]                 lanes_valid;

	modport source (
		output valid, acc_lane0, acc_lane1, acc_lane2, acc_lane3, lanes_valid,
		input  ready
	);
	modport sink (
		input  valid, acc_lane0, acc_lane1, acc_lane2, acc_lane3, lanes_valid,
		output ready
	);
endinterface

FILE: sv/rrm_act_if.sv
// ----------------------------------------------------------------------------
// rrm_act_if: activation channel
// Valid/ready channel carrying four activations and the pooled maximum.
// ----------------------------------------------------------------------------
interface rrm_act_if #(
	parameter int ACT_BITS = 4
);
	logic                       valid;
	logic                       ready;
	logic signed [ACT_BITS-1:0] act_lane0;
	logic signed [ACT_BITS-1:0] act_lane1;
	logic signed [ACT_BITS-1:0] act_lane2;
	logic signed [ACT_BITS-1:0] act_lane3;
	logic [ACT_BITS-2:0]        pool_max;

	modport source (
		output valid, act_lane0, act_lane1, act_lane2, act_lane3, pool_max,
		input  ready
	);
	modport sink (
		input  valid, act_lane0, act_lane1, act_lane2, act_lane3, pool_max,
		output ready
	);
endinterface

FILE: sv/rrm_cfg.sv
// ----------------------------------------------------------------------------
// rrm_cfg: configuration registers
// APB register file: scale multiplier, ReLU enable and the two clamps.
// ----------------------------------------------------------------------------
module rrm_cfg #(
	parameter int REQUANT_FRAC_BITS = 40,
	parameter int ACT_BITS          = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [rrm_pkg::PADDR_BITS-1:0]     paddr,
	input  logic [rrm_pkg::APB_DW-1:0]         pwdata,
	output logic [rrm_pkg::APB_DW-1:0]         prdata,
	output logic                               pready,
	output logic [rrm_pkg::SCALE_BITS-1:0]     scale,
	output logic                               relu,
	output logic signed [ACT_BITS-1:0]         clamp_low,
	output logic signed [ACT_BITS-1:0]         clamp_high
);
	import rrm_pkg::*;

	localparam logic [SCALE_BITS-1:0] SCALE_RST = SCALE_BITS'(1) << REQUANT_FRAC_BITS;
	localparam logic [ACT_BITS-1:0]   CLO_RST   = {1'b1, {(ACT_BITS-1){1'b0}}};
	localparam logic [ACT_BITS-1:0]   CHI_RST   = {1'b0, {(ACT_BITS-1){1'b1}}};

	reg_idx_t idx;
	logic     wr;

	// registers sit on 8-byte boundaries
	assign idx    = reg_idx_t'(paddr[4:3]);
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;

	logic [SCALE_BITS-1:0] scale_q;
	logic                  relu_q;
	logic [ACT_BITS-1:0]   clo_q;
	logic [ACT_BITS-1:0]   chi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RST;
			relu_q  <= 1'b1;
			clo_q   <= CLO_RST;
			chi_q   <= CHI_RST;
		end else if (wr) begin
			case (idx)
				REG_SCALE:    scale_q <= pwdata[SCALE_BITS-1:0];
				REG_RELU:     relu_q  <= pwdata[0];
				REG_CLAMP_LO: clo_q   <= pwdata[ACT_BITS-1:0];
				REG_CLAMP_HI: chi_q   <= pwdata[ACT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SCALE:    prdata = APB_DW'(scale_q);
			REG_RELU:     prdata = APB_DW'(relu_q);
			REG_CLAMP_LO: prdata = APB_DW'(clo_q);
			REG_CLAMP_HI: prdata = APB_DW'(chi_q);
			default:      prdata = '0;
		endcase
	end

	assign scale      = scale_q;
	assign relu       = relu_q;
	assign clamp_low  = signed'(clo_q);
	assign clamp_high = signed'(chi_q);

endmodule

FILE: sv/rrm_lane.sv
// ----------------------------------------------------------------------------
// rrm_lane: one requantization lane
// Magnitude, split multiply, product sum, round-half-even, ReLU and clamp
// over four pipeline stages.
// ----------------------------------------------------------------------------
module rrm_lane #(
	parameter int REQUANT_FRAC_BITS = 40,
	parameter int ACC_BITS          = 32,
	parameter int ACT_BITS          = 4
) (
	input  logic                           clk,
	input  rrm_pkg::pipe_ctl_t             ctl,
	input  logic signed [ACC_BITS-1:0]     acc,
	input  logic                           lane_on,
	input  logic [rrm_pkg::SCALE_BITS-1:0] scale,
	input  logic                           relu,
	input  logic signed [ACT_BITS-1:0]     clamp_low,
	input  logic signed [ACT_BITS-1:0]     clamp_high,
	output logic signed [ACT_BITS-1:0]     act_s4
);
	import rrm_pkg::*;

	localparam int F         = REQUANT_FRAC_BITS;
	localparam int HI_BITS   = SCALE_BITS - MUL_SPLIT;
	localparam int PLO_BITS  = ACC_BITS + MUL_SPLIT;
	localparam int PHI_BITS  = ACC_BITS + HI_BITS;
	localparam int PROD_BITS = ACC_BITS + SCALE_BITS;
	localparam int QW        = PROD_BITS - F;
	localparam int RW        = ACT_BITS + 2;
	localparam logic [PROD_BITS-1:0] STICKY_MASK = (PROD_BITS'(1) << (F - 1)) - PROD_BITS'(1);

	// stage 1: sign and magnitude
	logic                neg_s1, zero_s1, on_s1;
	logic [ACC_BITS-1:0] mag_s1;

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			neg_s1  <= acc[ACC_BITS-1];
			zero_s1 <= (acc == '0);
			on_s1   <= lane_on;
			mag_s1  <= acc[ACC_BITS-1] ? ACC_BITS'(-acc) : ACC_BITS'(acc);
		end
	end

	// stage 2: two partial products
	logic                neg_s2, zero_s2, on_s2;
	logic [PLO_BITS-1:0] plo_s2;
	logic [PHI_BITS-1:0] phi_s2;

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			neg_s2  <= neg_s1;
			zero_s2 <= zero_s1;
			on_s2   <= on_s1;
			plo_s2  <= PLO_BITS'(mag_s1) * PLO_BITS'(scale[MUL_SPLIT-1:0]);
			phi_s2  <= PHI_BITS'(mag_s1) * PHI_BITS'(scale[SCALE_BITS-1:MUL_SPLIT]);
		end
	end

	// stage 3: full product
	logic                 neg_s3, zero_s3, on_s3;
	logic [PROD_BITS-1:0] prod_s3;

	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;
			on_s3   <= on_s2;
			prod_s3 <= PROD_BITS'(plo_s2) + (PROD_BITS'(phi_s2) << MUL_SPLIT);
		end
	end

	// stage 4: round, saturate, sign, clamp
	logic [QW-1:0]              q_full;
	logic                       over, sticky, inc;
	logic [ACT_BITS:0]          q_sat;
	logic signed [RW-1:0]       r_val, r_hi, chi, clo;
	logic signed [ACT_BITS-1:0] act_d;

	always_comb begin
		q_full = prod_s3[PROD_BITS-1:F];
		// anything past the activation range ends up on a clamp anyway
		over   = |q_full[QW-1:ACT_BITS];
		sticky = |(prod_s3 & STICKY_MASK);
		inc    = prod_s3[F-1] & (sticky | q_full[0]);
		if (over)
			q_sat = {1'b1, {ACT_BITS{1'b0}}};
		else
			q_sat = {1'b0, q_full[ACT_BITS-1:0]} + (ACT_BITS+1)'(inc);
		r_val = neg_s3 ? -signed'(RW'(q_sat)) : signed'(RW'(q_sat));
		chi   = RW'(clamp_high);
		clo   = RW'(clamp_low);
		r_hi  = (r_val > chi) ? chi : r_val;
		if (r_hi < clo)
			r_hi = clo;
		// ReLU on a non-positive accumulator bypasses the clamps
		if (!on_s3 || (relu && (neg_s3 || zero_s3)))
			act_d = '0;
		else
			act_d = r_hi[ACT_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s4)
			act_s4 <= act_d;
	end

endmodule

FILE: sv/rrm_merge.sv
// ----------------------------------------------------------------------------
// rrm_merge: lane merge and output register
// Registers the lane results and the maximum over zero and all lanes.
// ----------------------------------------------------------------------------
module rrm_merge #(
	parameter int ACT_BITS = 4
) (
	input  logic                       clk,
	input  logic                       en_s5,
	input  logic signed [ACT_BITS-1:0] act_in [rrm_pkg::NUM_LANES],
	output logic signed [ACT_BITS-1:0] act_s5 [rrm_pkg::NUM_LANES],
	output logic [ACT_BITS-2:0]        pool_s5
);
	import rrm_pkg::*;

	logic signed [ACT_BITS-1:0] best;

	// idle lanes arrive as zero, so they never raise the maximum
	always_comb begin
		best = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			if (act_in[i] > best)
				best = act_in[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			act_s5  <= act_in;
			pool_s5 <= best[ACT_BITS-2:0];
		end
	end

endmodule

FILE: sv/requant_relu_maxpool_int4.sv
// ----------------------------------------------------------------------------
// requant_relu_maxpool_int4: requantize, ReLU and 2x2 max-pool
// Four lanes requantize signed accumulators to narrow activations; a merge
// stage registers the lanes and their pooled maximum.
// ----------------------------------------------------------------------------
// Usage:
//   acc carries one transaction per 2x2 window or group of four elements:
//   four accumulators and the number of leading lanes in use. act returns
//   one transaction per input: four activations (unused lanes read zero)
//   and the maximum of zero and the used lanes.
//   From an accepted input to act.valid the stages are magnitude,
//   split 32-bit multiply, product sum, rounding and clamp in each lane,
//   then the merge/output register. Throughput is one transaction per cycle
//   while act.ready is high; the lane multipliers are the per-stage limit.
//   Each stage holds its own valid flag, so acc.ready stays high while any
//   stage is empty; with act.ready low the pipeline fills and then acc.ready
//   drops until the receiver takes the waiting result.
//   The APB port writes the registers (8-byte stride); change them only
//   while the pipeline is empty. Reset empties the pipeline and restores
//   unity scale, ReLU on and the full activation range.
// ----------------------------------------------------------------------------
module requant_relu_maxpool_int4 #(
	parameter int REQUANT_FRAC_BITS = 40,
	parameter int ACC_BITS          = 32,
	parameter int ACT_BITS          = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [rrm_pkg::PADDR_BITS-1:0] paddr,
	input  logic [rrm_pkg::APB_DW-1:0]     pwdata,
	output logic [rrm_pkg::APB_DW-1:0]     prdata,
	output logic                           pready,
	rrm_acc_if.sink                        acc,
	rrm_act_if.source                      act
);
	import rrm_pkg::*;

	logic [SCALE_BITS-1:0]      scale;
	logic                       relu;
	logic signed [ACT_BITS-1:0] clamp_low, clamp_high;

	rrm_cfg #(
		.REQUANT_FRAC_BITS(REQUANT_FRAC_BITS),
		.ACT_BITS(ACT_BITS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.scale     (scale),
		.relu      (relu),
		.clamp_low (clamp_low),
		.clamp_high(clamp_high)
	);

	// stage valids and the ready chain back from the output register
	logic      valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic      rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	pipe_ctl_t ctl;

	assign rdy_s5    = !valid_s5 || act.ready;
	assign rdy_s4    = !valid_s4 || rdy_s5;
	assign rdy_s3    = !valid_s3 || rdy_s4;
	assign rdy_s2    = !valid_s2 || rdy_s3;
	assign rdy_s1    = !valid_s1 || rdy_s2;
	assign acc.ready = rdy_s1;

	assign ctl.en_s1 = rdy_s1;
	assign ctl.en_s2 = rdy_s2;
	assign ctl.en_s3 = rdy_s3;
	assign ctl.en_s4 = rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= acc.valid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (rdy_s4) valid_s4 <= valid_s3;
			if (rdy_s5) valid_s5 <= valid_s4;
		end
	end

	logic signed [ACC_BITS-1:0] lane_acc [NUM_LANES];
	logic signed [ACT_BITS-1:0] lane_act [NUM_LANES];
	logic signed [ACT_BITS-1:0] act_s5   [NUM_LANES];
	logic [ACT_BITS-2:0]        pool_s5;

	assign lane_acc[0] = acc.acc_lane0;
	assign lane_acc[1] = acc.acc_lane1;
	assign lane_acc[2] = acc.acc_lane2;
	assign lane_acc[3] = acc.acc_lane3;

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		rrm_lane #(
			.REQUANT_FRAC_BITS(REQUANT_FRAC_BITS),
			.ACC_BITS(ACC_BITS),
			.ACT_BITS(ACT_BITS)
		) u_lane (
			.clk       (clk),
			.ctl       (ctl),
			.acc       (lane_acc[i]),
			// counts above four enable every lane
			.lane_on   (acc.lanes_valid > LVALID_BITS'(i)),
			.scale     (scale),
			.relu      (relu),
			.clamp_low (clamp_low),
			.clamp_high(clamp_high),
			.act_s4    (lane_act[i])
		);
	end

	rrm_merge #(
		.ACT_BITS(ACT_BITS)
	) u_merge (
		.clk    (clk),
		.en_s5  (rdy_s5),
		.act_in (lane_act),
		.act_s5 (act_s5),
		.pool_s5(pool_s5)
	);

	assign act.valid     = valid_s5;
	assign act.act_lane0 = act_s5[0];
	assign act.act_lane1 = act_s5[1];
	assign act.act_lane2 = act_s5[2];
	assign act.act_lane3 = act_s5[3];
	assign act.pool_max  = pool_s5;

endmodule
